// ----- src/mtd_pkg.sv -----
// Shared constants and types for the multi-tap echo delay block.
// No dependencies; compiled before the interfaces and every module.
package mtd_pkg;

    // Default values for the top-level parameters.
    localparam int TAP_COUNT_DEF     = 4;
    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int SAMPLE_WIDTH_DEF  = 16;

    // Fixed register geometry.
    localparam int NUM_TAPS_MAX = 4;
    localparam int TAP_IDX_W    = 2;
    localparam int DELAY_W      = 12;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
    typedef logic [DELAY_W-1:0]       delay_t;
    typedef logic signed [GAIN_W-1:0] gain_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t REG_TAP0_DELAY = 3'd0;
    localparam cfg_idx_t REG_TAP1_DELAY = 3'd1;
    localparam cfg_idx_t REG_TAP2_DELAY = 3'd2;
    localparam cfg_idx_t REG_TAP3_DELAY = 3'd3;
    localparam cfg_idx_t REG_TAP0_GAIN  = 3'd4;
    localparam cfg_idx_t REG_TAP1_GAIN  = 3'd5;
    localparam cfg_idx_t REG_TAP2_GAIN  = 3'd6;
    localparam cfg_idx_t REG_TAP3_GAIN  = 3'd7;

endpackage

// ----- src/mtd_in_if.sv -----
// Input sample channel of the echo delay block: valid, ready and one sample.
// Depends on mtd_pkg for the default sample width.
interface mtd_in_if #(
    parameter int SAMPLE_WIDTH = mtd_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// ----- src/mtd_out_if.sv -----
// Result channel of the echo delay block: valid, ready, sample and clip flag.
// Depends on mtd_pkg for the default sample width.
interface mtd_out_if #(
    parameter int SAMPLE_WIDTH = mtd_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

// ----- src/mtd_cfg_if.sv -----
// Configuration write channel of the echo delay block: register index and data.
// Depends on mtd_pkg for the index and data types.
interface mtd_cfg_if;
    logic              valid;
    logic              ready;
    mtd_pkg::cfg_idx_t index;
    mtd_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/mtd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/multi_tap_echo_delay.sv -----
// Multi-tap echo delay: each input sample is returned plus up to four delayed,
// weighted copies of current or earlier input samples, rounded and saturated.
// Depends on mtd_pkg, mtd_in_if, mtd_out_if, mtd_cfg_if and mtd_ram.
//
// Use: samples arrive on the sample channel and one result per sample leaves
// on the result channel (out_sample, clipped). Registers are written on the
// cfg channel: indexes 0..3 are tap delays, 4..7 tap gains (signed Q1.15).
// Each sample runs through one history read per tap on the single RAM read
// port, one multiply per tap, then a rounding step that writes the new
// sample into the history RAM. A new sample is taken only after the previous
// one has left the rounding step.
// A delay write is reduced modulo HISTORY_DEPTH by a reciprocal multiplication,
// a quotient phase and then a remainder phase; cfg and sample channels are
// not ready until it is done.
// After reset the history RAM is cleared, one entry a cycle, through all
// HISTORY_DEPTH entries (4096 by default); no sample is taken during that
// pass, but register writes are. The result sits in an output register: the
// next sample is accepted while it waits, and a stalled receiver holds the
// block only at the rounding step of the following sample.
module multi_tap_echo_delay #(
    parameter int TAP_COUNT     = mtd_pkg::TAP_COUNT_DEF,
    parameter int HISTORY_DEPTH = mtd_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH  = mtd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mtd_in_if.sink     sample,
    mtd_out_if.source  result,
    mtd_cfg_if.sink    cfg
);

    import mtd_pkg::*;

    localparam int AW        = $clog2(HISTORY_DEPTH);
    localparam int SW        = SAMPLE_WIDTH;
    localparam int PROD_W    = SW + GAIN_W;
    localparam int ACC_W     = SW + GAIN_W + 3;
    localparam int Y_W       = ACC_W - GAIN_FRAC;
    localparam int STEP_W    = 3;
    localparam int RECIP_S   = DELAY_W + AW;
    localparam int RM_W      = DELAY_W + 2;
    localparam int RP_W      = DELAY_W + RM_W;

    localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(TAP_COUNT + 1);
    localparam logic [STEP_W-1:0]      NUM_TAPS  = STEP_W'(TAP_COUNT);
    localparam logic [AW-1:0]          LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]            DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
    localparam logic [RM_W-1:0]        RECIP_M   =
        RM_W'(((1 << RECIP_S) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam delay_t                 DEPTH_LOW = DELAY_W'(HISTORY_DEPTH);
    localparam logic signed [ACC_W-1:0] RND      = ACC_W'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [Y_W-1:0]  Y_MAX     = Y_W'((1 << (SW - 1)) - 1);
    localparam logic signed [Y_W-1:0]  Y_MIN     = Y_W'(-(1 << (SW - 1)));

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_ROUND
    } state_t;

    state_t                    state_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic [AW-1:0]             wp_reg;
    logic signed [SW-1:0]      x_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SW-1:0]      out_sample_reg;
    logic                      clipped_reg;
    logic                      out_vld_reg;

    logic [AW-1:0]             delay_mod_reg  [NUM_TAPS_MAX];
    logic                      delay_zero_reg [NUM_TAPS_MAX];
    gain_t                     gain_reg       [NUM_TAPS_MAX];

    logic                      red_busy_reg;
    logic                      red_phase_reg;
    logic [TAP_IDX_W-1:0]      red_tap_reg;
    delay_t                    red_val_reg;
    delay_t                    red_quot_reg;

    // Datapath and RAM port signals.
    logic [TAP_IDX_W-1:0]      iss_tap;
    logic [TAP_IDX_W-1:0]      prod_tap;
    logic [AW:0]               rd_diff;
    logic [AW-1:0]             ram_raddr;
    logic [SW-1:0]             ram_rdata;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [SW-1:0]             ram_wdata;
    logic signed [SW-1:0]      tap_sample;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [Y_W-1:0]     y_full;
    logic                      advance;
    logic [RP_W-1:0]           red_prod;
    delay_t                    red_quot;
    delay_t                    red_rem;

    // Handshake outputs.
    assign sample.ready      = (state_reg == S_IDLE) && !red_busy_reg;
    assign cfg.ready         = !red_busy_reg;
    assign result.valid      = out_vld_reg;
    assign result.out_sample = out_sample_reg;
    assign result.clipped    = clipped_reg;

    // History read address: write pointer minus the reduced delay, wrapped.
    assign iss_tap   = step_reg[TAP_IDX_W-1:0];
    assign prod_tap  = TAP_IDX_W'(step_reg - STEP_W'(1));
    assign rd_diff   = {1'b0, wp_reg} - {1'b0, delay_mod_reg[iss_tap]};
    assign ram_raddr = rd_diff[AW] ? AW'(rd_diff + DEPTH_EXT) : rd_diff[AW-1:0];

    // Tap product: a zero delay takes the current sample instead of the history.
    assign tap_sample = delay_zero_reg[prod_tap] ? x_reg : $signed(ram_rdata);
    assign prod_full  = tap_sample * gain_reg[prod_tap];

    // Round half up, drop the fraction bits.
    assign acc_rnd = acc_reg + RND;
    assign y_full  = acc_rnd[ACC_W-1:GAIN_FRAC];
    assign advance = (state_reg == S_ROUND) && (!out_vld_reg || result.ready);

    // RAM write port: clearing pass, then one new sample per item.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = x_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (advance)
        begin
            ram_we = 1'b1;
        end
    end

    mtd_ram #(
        .WIDTH (SW),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: clear pass, accept, per-tap read and multiply-accumulate, round.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            step_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (result.ready && !advance)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (sample.valid && sample.ready)
                    begin
                        x_reg     <= sample.in_sample;
                        acc_reg   <= ACC_W'(sample.in_sample) <<< GAIN_FRAC;
                        step_reg  <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (step_reg >= STEP_W'(1) && step_reg <= NUM_TAPS)
                    begin
                        prod_reg <= prod_full;
                    end
                    if (step_reg >= STEP_W'(2))
                    begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    if (advance)
                    begin
                        if (y_full > Y_MAX)
                        begin
                            out_sample_reg <= SW'(Y_MAX);
                            clipped_reg    <= 1'b1;
                        end
                        else if (y_full < Y_MIN)
                        begin
                            out_sample_reg <= SW'(Y_MIN);
                            clipped_reg    <= 1'b1;
                        end
                        else
                        begin
                            out_sample_reg <= SW'(y_full);
                            clipped_reg    <= 1'b0;
                        end
                        out_vld_reg <= 1'b1;
                        wp_reg      <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Delay reduction modulo the history depth: the quotient comes from a
    // multiplication by the rounded-up reciprocal, exact for every 12-bit delay,
    // and the remainder from a multiply-subtract in the following cycle.
    assign red_prod = RP_W'(red_val_reg) * RP_W'(RECIP_M);
    assign red_quot = DELAY_W'(red_prod >> RECIP_S);
    assign red_rem  = red_val_reg - DELAY_W'(red_quot_reg * DEPTH_LOW);

    // Configuration registers and the reduction unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TAPS_MAX; k++)
            begin
                delay_mod_reg[k]  <= AW'(1);
                delay_zero_reg[k] <= 1'b0;
                gain_reg[k]       <= '0;
            end
            red_busy_reg  <= 1'b0;
            red_phase_reg <= 1'b0;
            red_tap_reg   <= '0;
            red_val_reg   <= '0;
            red_quot_reg  <= '0;
        end
        else if (red_busy_reg)
        begin
            if (!red_phase_reg)
            begin
                red_quot_reg  <= red_quot;
                red_phase_reg <= 1'b1;
            end
            else
            begin
                red_busy_reg               <= 1'b0;
                red_phase_reg              <= 1'b0;
                delay_mod_reg[red_tap_reg] <= AW'(red_rem);
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index) inside
                REG_TAP0_DELAY, REG_TAP1_DELAY, REG_TAP2_DELAY, REG_TAP3_DELAY:
                begin
                    red_busy_reg <= 1'b1;
                    red_tap_reg  <= cfg.index[TAP_IDX_W-1:0];
                    red_val_reg  <= cfg.data[DELAY_W-1:0];
                    delay_zero_reg[cfg.index[TAP_IDX_W-1:0]] <=
                        (cfg.data[DELAY_W-1:0] == '0);
                end
                REG_TAP0_GAIN, REG_TAP1_GAIN, REG_TAP2_GAIN, REG_TAP3_GAIN:
                begin
                    gain_reg[cfg.index[TAP_IDX_W-1:0]] <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // An accepted sample always starts the tap sequence from its first step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> state_reg == S_RUN && step_reg == '0)
        else $error("sample transfer did not start the tap sequence");

    // A waiting result is never overwritten by the next rounding cycle.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND && out_vld_reg && !result.ready
        |=> out_vld_reg && $stable(out_sample_reg) && $stable(clipped_reg))
        else $error("pending result overwritten");

    // The write pointer stays inside the history memory.
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_ADDR)
        else $error("write pointer out of range");

    // The reduction unit finishes after its remainder phase.
    a_reduce_done: assert property (@(posedge clk) disable iff (!rst_n)
        red_busy_reg && red_phase_reg |=> !red_busy_reg)
        else $error("delay reduction did not finish");

endmodule

// ----- tb/sv/multi_tap_echo_delay_test.sv -----
// Self-checking testbench for multi_tap_echo_delay: drives samples and tap settings,
// predicts each echo result in its own model of the taps and compares every transfer.
// Depends on mtd_pkg, mtd_in_if, mtd_out_if, mtd_cfg_if and the block's RTL.
module multi_tap_echo_delay_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mtd_pkg::*;

    localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int SAMP_W       = SAMPLE_WIDTH_DEF;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HALF_SEGMENT = 54;
    localparam int SEGMENTS     = 10;

    typedef logic signed [SAMP_W-1:0] sample_t;

    typedef struct packed {
        sample_t out_sample;
        logic    clipped;
    } echo_t;

    typedef struct packed {
        cfg_idx_t  index;
        cfg_data_t data;
    } reg_write_t;

    localparam cfg_idx_t DELAY_REG [NUM_TAPS_MAX] =
        '{REG_TAP0_DELAY, REG_TAP1_DELAY, REG_TAP2_DELAY, REG_TAP3_DELAY};
    localparam cfg_idx_t GAIN_REG [NUM_TAPS_MAX] =
        '{REG_TAP0_GAIN, REG_TAP1_GAIN, REG_TAP2_GAIN, REG_TAP3_GAIN};

    // Directed samples: full-scale values, sign boundaries and repeated extremes
    // that drive the sum into both saturation limits.
    localparam sample_t EDGE_SAMPLES [17] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh4000,
        16'sh3FFF, 16'shC000, 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF,
        16'sh8000, 16'sh8000, 16'sh0003, 16'shFFFD, 16'sh3039
    };
    // Half-LSB echoes that check the round-half-up step in both signs.
    localparam sample_t ROUNDING_SAMPLES [4] =
        '{16'sh4000, 16'sh0000, 16'shC000, 16'sh0000};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mtd_in_if  sample_ch ();
    mtd_out_if result_ch ();
    mtd_cfg_if cfg_ch ();

    multi_tap_echo_delay i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state: tap registers, sample history and its write slot.
    delay_t  tap_delay [NUM_TAPS_MAX];
    gain_t   tap_gain [NUM_TAPS_MAX];
    sample_t echo_history [HIST_DEPTH];
    int      write_slot;

    // Stimulus queues and the store of predicted echo results.
    sample_t    pending_samples [$];
    reg_write_t pending_writes [$];
    echo_t      expected_echoes [$];

    // Tap setting to be applied next by apply_taps.
    delay_t next_delay [NUM_TAPS_MAX];
    gain_t  next_gain [NUM_TAPS_MAX];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int echo_checks       = 0;
    int clip_count        = 0;
    int mismatches        = 0;
    int settings_applied  = 0;
    int quiet_cycles      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Echo sum for one sample: exact accumulation, round half up, saturate.
    // Also stores the sample in the history, as the block does.
    function automatic echo_t predict_echo(input sample_t x);
        longint  acc;
        longint  y;
        sample_t tapped;
        int      slot;
        echo_t   r;
        acc = longint'(x) <<< GAIN_FRAC;
        for (int k = 0; k < TAP_COUNT_DEF; k++)
        begin
            if (tap_delay[k] == '0)
                tapped = x;
            else
            begin
                slot = (write_slot + HIST_DEPTH - int'(tap_delay[k]) % HIST_DEPTH) % HIST_DEPTH;
                tapped = echo_history[slot];
            end
            acc += longint'(tapped) * longint'(tap_gain[k]);
        end
        y = (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        r.clipped = 1'b0;
        if (y > longint'((1 << (SAMP_W - 1)) - 1))
        begin
            y = (1 << (SAMP_W - 1)) - 1;
            r.clipped = 1'b1;
        end
        else if (y < -longint'(1 << (SAMP_W - 1)))
        begin
            y = -longint'(1 << (SAMP_W - 1));
            r.clipped = 1'b1;
        end
        r.out_sample = sample_t'(y);
        echo_history[write_slot] = x;
        write_slot = (write_slot + 1) % HIST_DEPTH;
        return r;
    endfunction

    // Driver: sample and register channels from their queues, random result ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid     <= 1'b0;
            sample_ch.in_sample <= '0;
            cfg_ch.valid        <= 1'b0;
            cfg_ch.index        <= REG_TAP0_DELAY;
            cfg_ch.data         <= '0;
            result_ch.ready     <= 1'b0;
        end
        else
        begin
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    sample_ch.valid     <= 1'b1;
                    sample_ch.in_sample <= pending_samples.pop_front();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    reg_write_t w;
                    w = pending_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= w.index;
                    cfg_ch.data  <= w.data;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Monitor: updates the predictor on each transfer, checks results, and
    // ends the run if no transfer happens for too long. During reset the
    // predictor returns to the reset tap setting and a cleared history.
    always @(posedge clk)
    begin
        echo_t want;
        echo_t pred;
        logic  moved;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TAPS_MAX; k++)
            begin
                tap_delay[k] = delay_t'(1);
                tap_gain[k]  = '0;
            end
            foreach (echo_history[i])
                echo_history[i] = '0;
            write_slot   = 0;
            quiet_cycles = 0;
        end
        else
        begin
            moved = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                for (int k = 0; k < NUM_TAPS_MAX; k++)
                begin
                    if (cfg_ch.index == DELAY_REG[k])
                        tap_delay[k] = cfg_ch.data[DELAY_W-1:0];
                    if (cfg_ch.index == GAIN_REG[k])
                        tap_gain[k] = gain_t'(cfg_ch.data);
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                moved = 1'b1;
                pred = predict_echo(sample_ch.in_sample);
                expected_echoes = {expected_echoes, pred};
            end
            if (result_ch.valid && result_ch.ready)
            begin
                moved = 1'b1;
                echo_checks++;
                if (result_ch.clipped)
                    clip_count++;
                if (expected_echoes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with no sample waiting (out_sample %0d)",
                             $time, result_ch.out_sample);
                end
                else
                begin
                    want = expected_echoes.pop_front();
                    if (result_ch.out_sample !== want.out_sample)
                    begin
                        mismatches++;
                        $display("%0t: out_sample expected %0d, got %0d",
                                 $time, want.out_sample, result_ch.out_sample);
                    end
                    if (result_ch.clipped !== want.clipped)
                    begin
                        mismatches++;
                        $display("%0t: clipped expected %0b, got %0b",
                                 $time, want.clipped, result_ch.clipped);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_echoes.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Waits until every queued sample has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_echoes.size() != 0)
            @(negedge clk);
    endtask

    // Writes all eight tap registers from next_delay and next_gain; the spare
    // high bits of each delay write carry random values that must be ignored.
    task automatic apply_taps();
        reg_write_t w;
        for (int k = 0; k < NUM_TAPS_MAX; k++)
        begin
            w.index = DELAY_REG[k];
            w.data  = {(CFG_DATA_W - DELAY_W)'($urandom()), next_delay[k]};
            pending_writes = {pending_writes, w};
        end
        for (int k = 0; k < NUM_TAPS_MAX; k++)
        begin
            w.index = GAIN_REG[k];
            w.data  = cfg_data_t'(next_gain[k]);
            pending_writes = {pending_writes, w};
        end
        while (pending_writes.size() != 0 || cfg_ch.valid)
            @(negedge clk);
        settings_applied++;
    endtask

    initial
    begin
        sample_t x;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, sender mostly busy and receiver often stalled.
        sender_idle_pct   = 11;
        receiver_idle_pct = 62;

        // Reset tap setting: every gain zero, so each result is the sample itself.
        pending_samples = {pending_samples, 16'sh0064};
        pending_samples = {pending_samples, 16'shFF9C};
        pending_samples = {pending_samples, 16'sh7FFF};
        pending_samples = {pending_samples, 16'sh8000};
        wait_drained();

        // Zero-delay tap at full positive gain, a unit-delay tap at -1.0, the
        // longest delay reading cleared history, and a disabled tap.
        next_delay = '{delay_t'(0), delay_t'(1), '1, delay_t'(2)};
        next_gain  = '{16'sh7FFF, 16'sh8000, 16'sh4000, 16'sh0000};
        apply_taps();
        foreach (EDGE_SAMPLES[i])
            pending_samples = {pending_samples, EDGE_SAMPLES[i]};
        wait_drained();

        // Smallest gain on one tap: echoes of exactly half an LSB.
        next_delay = '{delay_t'(1), delay_t'(1), delay_t'(1), delay_t'(1)};
        next_gain  = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000};
        apply_taps();
        foreach (ROUNDING_SAMPLES[i])
            pending_samples = {pending_samples, ROUNDING_SAMPLES[i]};
        wait_drained();

        // Random part: one tap setting per segment, with a full drain halfway.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                sender_idle_pct   = 11;
                receiver_idle_pct = 62;
            end
            else if (seg < 7)
            begin
                sender_idle_pct   = 62;
                receiver_idle_pct = 11;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            for (int k = 0; k < NUM_TAPS_MAX; k++)
            begin
                case (seg)
                    1:
                    begin
                        next_delay[k] = delay_t'(k);
                        next_gain[k]  = 16'sh7FFF;
                    end
                    4:
                    begin
                        next_delay[k] = (k == 0) ? '1 : delay_t'(k);
                        next_gain[k]  = 16'sh8000;
                    end
                    7:
                    begin
                        next_delay[k] = delay_t'($urandom_range(1, 200));
                        next_gain[k]  = '0;
                    end
                    default:
                    begin
                        case ($urandom_range(7))
                            0: next_delay[k] = '0;
                            1: next_delay[k] = '1;
                            2: next_delay[k] = delay_t'($urandom());
                            default: next_delay[k] = delay_t'($urandom_range(1, 64));
                        endcase
                        if ($urandom_range(1))
                            next_gain[k] = gain_t'($urandom());
                        else
                            next_gain[k] = gain_t'($urandom()) >>> 2;
                    end
                endcase
            end
            apply_taps();

            for (int half = 0; half < 2; half++)
            begin
                for (int n = 0; n < HALF_SEGMENT; n++)
                begin
                    case ($urandom_range(9))
                        0: x = 16'sh7FFF;
                        1: x = 16'sh8000;
                        2, 3: x = sample_t'(int'($urandom_range(512)) - 256);
                        default: x = sample_t'($urandom());
                    endcase
                    pending_samples = {pending_samples, x};
                end
                wait_drained();
            end
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(negedge clk);
        $display("Checked %0d echo results (%0d saturated) over %0d tap settings,",
                 echo_checks, clip_count, settings_applied);
        $display("including zero, unit and longest delays and gains from -1.0 to +1.0.");
        if (mismatches == 0 && expected_echoes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- multi_tap_echo_delay.f -----
src/mtd_pkg.sv
src/mtd_in_if.sv
src/mtd_out_if.sv
src/mtd_cfg_if.sv
src/mtd_ram.sv
src/multi_tap_echo_delay.sv
tb/sv/multi_tap_echo_delay_test.sv
